/* sv/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Types, constants and codes shared by the station learning table modules.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int AP_SLOTS     = 32;
   localparam int CLIENT_SLOTS = 64;

   localparam int AP_IDX_W = $clog2(AP_SLOTS);
   localparam int AP_N_W   = $clog2(AP_SLOTS + 1);
   localparam int CL_IDX_W = $clog2(CLIENT_SLOTS);
   localparam int FILL_W   = $clog2(CLIENT_SLOTS + 1);

   localparam int ADDR_W  = 48;
   localparam int COUNT_W = 32;
   localparam int CNT_CFG_W = 6;

   localparam logic [15:0]       MIN_LEN_EXCL = 16'd27;
   localparam logic [ADDR_W-1:0] BCAST_ADDR   = {ADDR_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

   // register indexes on the csr port
   localparam logic CSR_SCAN_ENABLE = 1'b0;
   localparam logic CSR_AP_COUNT    = 1'b1;

   typedef enum logic [1:0] {
      FUNC_FRAME = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_FRAME
   } op_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AP_RD,
      S_AP_CMP,
      S_CL_RD,
      S_CL_CMP,
      S_MISS,
      S_CNT_RD,
      S_CNT_WR,
      S_DONE
   } back_state_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [15:0]         frame_length;
      logic [ADDR_W-1:0]   source_address;
      logic [ADDR_W-1:0]   dest_address;
      logic [4:0]          ap_slot;
      logic [ADDR_W-1:0]   ap_address;
      logic                ap_chosen;
   } req_type;

   typedef struct packed {
      logic                matched;
      logic [5:0]          client_slot;
      logic                new_client;
      logic                table_full;
      logic [COUNT_W-1:0]  frame_count;
      logic [6:0]          client_total;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      op_kind_type         kind;
      logic [AP_N_W-1:0]   ap_limit;
      logic [ADDR_W-1:0]   src;
      logic [ADDR_W-1:0]   dst;
      logic [AP_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]   ap_addr;
      logic                chosen;
   } op_type;

endpackage

/* sv/station_learning_table.sv */
// ----------------------------------------------------------------------------
// station_learning_table
// Learns client addresses from captured frames sent by selected access points.
// ----------------------------------------------------------------------------
// One item is processed at a time and gives exactly one result. Load, clear
// and ignored items go straight to the result. A counted frame walks the N
// access point entries in use and then compares M clients before a hit,
// where N comes from ap_count (at most 32) and M
// is at most the fill, 64: the access point and client tables are single-port
// memories read one entry at a time, each read followed by a compare. A
// two-entry queue sits between the input side and the table engine, and a
// result register frees the engine while a result waits.
module station_learning_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   input  logic              req_valid,
   output logic              req_ready,
   input  slt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slt_pkg::rsp_type  rsp_data
);
   import slt_pkg::*;

   logic   f_valid, f_ready, b_valid, b_ready;
   op_type f_data, b_data;

   slt_front u_front (
      .clock, .reset,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready,
      .req_valid, .req_ready, .req_data,
      .op_valid (f_valid), .op_ready (f_ready), .op_data (f_data)
   );

   slt_queue u_queue (
      .clock, .reset,
      .in_valid (f_valid), .in_ready (f_ready), .in_data (f_data),
      .out_valid (b_valid), .out_ready (b_ready), .out_data (b_data)
   );

   slt_back u_back (
      .clock, .reset,
      .op_valid (b_valid), .op_ready (b_ready), .op_data (b_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

/* sv/slt_front.sv */
// ----------------------------------------------------------------------------
// slt_front
// Configuration registers and item classification.
// ----------------------------------------------------------------------------
module slt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   input  logic              req_valid,
   output logic              req_ready,
   input  slt_pkg::req_type  req_data,
   output logic              op_valid,
   input  logic              op_ready,
   output slt_pkg::op_type   op_data
);
   import slt_pkg::*;

   localparam logic [AP_N_W-1:0] AP_LIMIT = AP_N_W'(AP_SLOTS);

   logic                 scan_enable_ff, scan_enable_in;
   logic [CNT_CFG_W-1:0] ap_count_ff, ap_count_in;
   logic                 csr_wr;
   logic                 eligible;
   logic [AP_N_W:0]      ap_count_ext;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      scan_enable_in = scan_enable_ff;
      ap_count_in    = ap_count_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_SCAN_ENABLE: scan_enable_in = csr_pwdata[0];
            CSR_AP_COUNT:    ap_count_in    = csr_pwdata[CNT_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_enable_ff <= 1'b0;
         ap_count_ff    <= '0;
      end else begin
         scan_enable_ff <= scan_enable_in;
         ap_count_ff    <= ap_count_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_SCAN_ENABLE: csr_prdata = {31'd0, scan_enable_ff};
         CSR_AP_COUNT:    csr_prdata = {{(32-CNT_CFG_W){1'b0}}, ap_count_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign eligible = scan_enable_ff && (req_data.frame_length > MIN_LEN_EXCL)
                     && (req_data.dest_address != BCAST_ADDR);
   assign ap_count_ext = (AP_N_W+1)'(ap_count_ff);

   always_comb begin
      op_data.ap_limit = (ap_count_ext > {1'b0, AP_LIMIT}) ? AP_LIMIT
                                                          : ap_count_ext[AP_N_W-1:0];
      op_data.src     = req_data.source_address;
      op_data.dst     = req_data.dest_address;
      op_data.slot    = req_data.ap_slot[AP_IDX_W-1:0];
      op_data.ap_addr = req_data.ap_address;
      op_data.chosen  = req_data.ap_chosen;
      case (func_type'(req_data.func))
         FUNC_FRAME: op_data.kind = eligible ? OP_FRAME : OP_NONE;
         FUNC_LOAD:  op_data.kind = ((AP_N_W+1)'(req_data.ap_slot) < {1'b0, AP_LIMIT})
                                    ? OP_LOAD : OP_NONE;
         FUNC_CLEAR: op_data.kind = OP_CLEAR;
         default:    op_data.kind = OP_NONE;
      endcase
   end

   assign op_valid  = req_valid;
   assign req_ready = op_ready;

endmodule

/* sv/slt_queue.sv */
// ----------------------------------------------------------------------------
// slt_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module slt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  slt_pkg::op_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output slt_pkg::op_type  out_data
);
   import slt_pkg::*;

   op_type     entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_data;
   end

endmodule

/* sv/slt_back.sv */
// ----------------------------------------------------------------------------
// slt_back
// Access point table, client table and counters; runs one item at a time.
// ----------------------------------------------------------------------------
module slt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   output logic             op_ready,
   input  slt_pkg::op_type  op_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slt_pkg::rsp_type rsp_data
);
   import slt_pkg::*;

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CLIENT_SLOTS);

   back_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   logic [AP_N_W-1:0]   ap_idx_ff, ap_idx_in;
   logic [AP_N_W-1:0]   hits_ff, hits_in;
   logic [FILL_W-1:0]   cl_idx_ff, cl_idx_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [CL_IDX_W-1:0] slot_ff, slot_in;
   logic                matched_ff, matched_in;
   logic                new_ff, new_in;
   logic                full_ff, full_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [AP_SLOTS-1:0]     marks_ff, marks_in;
   logic [CLIENT_SLOTS-1:0] cvalid_ff, cvalid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [ADDR_W-1:0]  ap_mem [AP_SLOTS];
   logic [ADDR_W-1:0]  cl_mem [CLIENT_SLOTS];
   logic [COUNT_W-1:0] cnt_mem [CLIENT_SLOTS];
   logic [ADDR_W-1:0]  ap_rd_ff, cl_rd_ff;
   logic [COUNT_W-1:0] cnt_rd_ff;

   logic ap_we, ap_re, cl_we, cl_re, cnt_we, cnt_re;
   logic [COUNT_W-1:0] cnt_base, cnt_new;
   logic [COUNT_W:0]   cnt_sum;
   logic [AP_N_W-1:0]  hits_nx;

   assign op_ready  = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cnt_base = cvalid_ff[slot_ff] ? cnt_rd_ff : '0;
   assign cnt_sum  = {1'b0, cnt_base} + (COUNT_W+1)'(hits_ff);
   assign cnt_new  = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      ap_idx_in  = ap_idx_ff;
      hits_in    = hits_ff;
      cl_idx_in  = cl_idx_ff;
      fill_in    = fill_ff;
      slot_in    = slot_ff;
      matched_in = matched_ff;
      new_in     = new_ff;
      full_in    = full_ff;
      count_in   = count_ff;
      marks_in   = marks_ff;
      cvalid_in  = cvalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in     = rsp_ff;
      ap_we = 1'b0; ap_re = 1'b0; cl_we = 1'b0; cl_re = 1'b0;
      cnt_we = 1'b0; cnt_re = 1'b0;
      hits_nx = hits_ff + AP_N_W'(marks_ff[ap_idx_ff[AP_IDX_W-1:0]]
                                  && (ap_rd_ff == op_ff.src));
      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_in      = op_data;
               ap_idx_in  = '0;
               hits_in    = '0;
               cl_idx_in  = '0;
               slot_in    = '0;
               matched_in = 1'b0;
               new_in     = 1'b0;
               full_in    = 1'b0;
               count_in   = '0;
               state_in   = S_DONE;
               case (op_data.kind)
                  OP_LOAD: begin
                     ap_we = 1'b1;
                     marks_in[op_data.slot] = op_data.chosen;
                  end
                  OP_CLEAR: begin
                     fill_in   = '0;
                     cvalid_in = '0;
                  end
                  OP_FRAME: if (op_data.ap_limit != '0) state_in = S_AP_RD;
                  default: ;
               endcase
            end
         end
         S_AP_RD: begin
            ap_re    = 1'b1;
            state_in = S_AP_CMP;
         end
         S_AP_CMP: begin
            hits_in   = hits_nx;
            ap_idx_in = ap_idx_ff + 1'b1;
            if (ap_idx_ff + 1'b1 != op_ff.ap_limit)   state_in = S_AP_RD;
            else if (hits_nx == '0)                  state_in = S_DONE;
            else if (fill_ff == '0)                  state_in = S_MISS;
            else                                     state_in = S_CL_RD;
         end
         S_CL_RD: begin
            cl_re    = 1'b1;
            state_in = S_CL_CMP;
         end
         S_CL_CMP: begin
            if (cl_rd_ff == op_ff.dst) begin
               slot_in  = cl_idx_ff[CL_IDX_W-1:0];
               state_in = S_CNT_RD;
            end else begin
               cl_idx_in = cl_idx_ff + 1'b1;
               state_in  = (cl_idx_ff + 1'b1 == fill_ff) ? S_MISS : S_CL_RD;
            end
         end
         S_MISS: begin
            if (fill_ff == FILL_FULL) begin
               full_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               slot_in  = fill_ff[CL_IDX_W-1:0];
               cl_we    = 1'b1;
               cvalid_in[fill_ff[CL_IDX_W-1:0]] = 1'b0;
               fill_in  = fill_ff + 1'b1;
               new_in   = 1'b1;
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            cnt_re   = 1'b1;
            state_in = S_CNT_WR;
         end
         S_CNT_WR: begin
            cnt_we     = 1'b1;
            cvalid_in[slot_ff] = 1'b1;
            count_in   = cnt_new;
            matched_in = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.matched      = matched_ff;
               rsp_in.client_slot  = 6'(slot_ff);
               rsp_in.new_client   = new_ff;
               rsp_in.table_full   = full_ff;
               rsp_in.frame_count  = count_ff;
               rsp_in.client_total = 7'(fill_ff);
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         marks_ff     <= '0;
         cvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         marks_ff     <= marks_in;
         cvalid_ff    <= cvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ap_idx_ff  <= ap_idx_in;
      hits_ff    <= hits_in;
      cl_idx_ff  <= cl_idx_in;
      slot_ff    <= slot_in;
      matched_ff <= matched_in;
      new_ff     <= new_in;
      full_ff    <= full_in;
      count_ff   <= count_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (ap_we) ap_mem[op_data.slot] <= op_data.ap_addr;
      if (ap_re) ap_rd_ff <= ap_mem[ap_idx_ff[AP_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cl_we) cl_mem[fill_ff[CL_IDX_W-1:0]] <= op_ff.dst;
      if (cl_re) cl_rd_ff <= cl_mem[cl_idx_ff[CL_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[slot_ff] <= cnt_new;
      if (cnt_re) cnt_rd_ff <= cnt_mem[slot_ff];
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL) else $error("client fill beyond table size");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != $past(fill_ff)) |-> (fill_ff == '0 || fill_ff == $past(fill_ff) + 1'b1))
      else $error("client fill moved by more than one");

   a_new_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.new_client && rsp_ff.table_full))
      else $error("item both inserted and dropped");

   a_full_unmatched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.table_full) |-> !rsp_ff.matched)
      else $error("dropped item reported as matched");

endmodule

/* test/slt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slt_checker
// Watches the csr, request and response ports of the station learning table,
// keeps its own copy of the access point and client tables, predicts one
// response per accepted request and compares every field in order.
// ----------------------------------------------------------------------------
module slt_checker
   import slt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int          fail_count,
   output int          pending,
   output int          matched_total,
   output int          new_total,
   output int          full_total
);

   logic                scan_on;
   logic [5:0]          ap_limit;
   logic [ADDR_W-1:0]   ap_addr [AP_SLOTS];
   logic                ap_mark [AP_SLOTS];
   logic [ADDR_W-1:0]   cl_addr [CLIENT_SLOTS];
   logic [COUNT_W-1:0]  cl_count [CLIENT_SLOTS];
   int                  cl_fill;
   rsp_type             expected_rsp [$];

   assign pending = expected_rsp.size();

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // advances the table copy by one request and returns its response
   function automatic rsp_type learn_item(req_type r);
      rsp_type o;
      int      lim;
      int      hit;
      o = '0;
      if (r.func == FUNC_LOAD) begin
         ap_addr[r.ap_slot] = r.ap_address;
         ap_mark[r.ap_slot] = r.ap_chosen;
      end else if (r.func == FUNC_CLEAR) begin
         cl_fill = 0;
         for (int k = 0; k < CLIENT_SLOTS; k++) cl_count[k] = '0;
      end else if (r.func == FUNC_FRAME && scan_on && r.frame_length > MIN_LEN_EXCL
                   && r.dest_address != BCAST_ADDR) begin
         lim = (ap_limit > AP_SLOTS) ? AP_SLOTS : ap_limit;
         for (int i = 0; i < lim; i++) begin
            if (!ap_mark[i] || ap_addr[i] != r.source_address) continue;
            hit = cl_fill;
            for (int k = 0; k < cl_fill; k++) begin
               if (cl_addr[k] == r.dest_address) begin
                  hit = k;
                  break;
               end
            end
            if (hit >= cl_fill) begin
               if (cl_fill >= CLIENT_SLOTS) begin
                  o.table_full = 1'b1;
                  continue;
               end
               hit = cl_fill;
               cl_addr[hit] = r.dest_address;
               cl_count[hit] = '0;
               cl_fill++;
               o.new_client = 1'b1;
            end
            if (cl_count[hit] != COUNT_MAX) cl_count[hit]++;
            o.matched = 1'b1;
            o.client_slot = hit[5:0];
            o.frame_count = cl_count[hit];
         end
      end
      o.client_total = cl_fill[6:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         scan_on <= 1'b0;
         ap_limit <= '0;
         fail_count = 0;
         matched_total = 0;
         new_total = 0;
         full_total = 0;
         cl_fill = 0;
         expected_rsp.delete();
         for (int i = 0; i < AP_SLOTS; i++) ap_mark[i] = 1'b0;
         for (int k = 0; k < CLIENT_SLOTS; k++) cl_count[k] = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == CSR_AP_COUNT) ap_limit <= csr_pwdata[5:0];
            else scan_on <= csr_pwdata[0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_data, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.matched !== want.matched)
                  report_mismatch("matched", rsp_data.matched, want.matched);
               if (rsp_data.client_slot !== want.client_slot)
                  report_mismatch("client_slot", rsp_data.client_slot, want.client_slot);
               if (rsp_data.new_client !== want.new_client)
                  report_mismatch("new_client", rsp_data.new_client, want.new_client);
               if (rsp_data.table_full !== want.table_full)
                  report_mismatch("table_full", rsp_data.table_full, want.table_full);
               if (rsp_data.frame_count !== want.frame_count)
                  report_mismatch("frame_count", rsp_data.frame_count, want.frame_count);
               if (rsp_data.client_total !== want.client_total)
                  report_mismatch("client_total", rsp_data.client_total,
                                  want.client_total);
               matched_total += want.matched;
               new_total += want.new_client;
               full_total += want.table_full;
            end
         end
         if (req_valid && req_ready) expected_rsp.push_back(learn_item(req_data));
      end
   end

endmodule

/* test/tb_station_learning_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_station_learning_table
// Drives access point loads, client clears and captured frames into the
// station learning table under several register settings and idle patterns;
// a separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_station_learning_table;
   import slt_pkg::*;

   localparam int STALL_LIMIT = 40000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   int fail_count, pending, matched_total, new_total, full_total;
   int idle_mode = 0;            // 0 none, 1 sender, 2 receiver, 3 both
   logic hold_kick = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int items_sent = 0;

   logic [ADDR_W-1:0] ap_pool [8];
   logic [ADDR_W-1:0] dest_pool [100];

   always #1 clock = ~clock;

   station_learning_table u_dut (.*);

   slt_checker u_checker (.*);

   // response side: random stalls, plus one long hold-off when kicked
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_mode == 2) rsp_ready <= ($urandom_range(99) >= 86);
      else if (idle_mode == 3) rsp_ready <= ($urandom_range(99) >= 23);
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   task automatic csr_write(logic idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send(req_type r);
      logic took;
      int   gap_pct;
      gap_pct = (idle_mode == 1) ? 86 : (idle_mode == 3) ? 23 : 0;
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      items_sent++;
   endtask

   // waits first so the checker has queued the last accepted item
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic req_type make_item(logic [1:0] f, logic [15:0] len,
                                         logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst);
      req_type r;
      r.func = f;
      r.frame_length = len;
      r.source_address = src;
      r.dest_address = dst;
      r.ap_slot = 5'($urandom);
      r.ap_address = rand_addr();
      r.ap_chosen = 1'($urandom);
      return r;
   endfunction

   function automatic req_type load_item(logic [4:0] slot, logic [ADDR_W-1:0] a, logic mark);
      req_type r;
      r = make_item(FUNC_LOAD, 16'($urandom), rand_addr(), rand_addr());
      r.ap_slot = slot;
      r.ap_address = a;
      r.ap_chosen = mark;
      return r;
   endfunction

   function automatic req_type frame_item(logic [15:0] len, logic [ADDR_W-1:0] src,
                                          logic [ADDR_W-1:0] dst);
      return make_item(FUNC_FRAME, len, src, dst);
   endfunction

   function automatic req_type random_item();
      int      pick;
      req_type r;
      pick = $urandom_range(999);
      r = make_item(2'($urandom), 16'($urandom), rand_addr(), rand_addr());
      if (pick < 650) begin
         r.func = FUNC_FRAME;
         r.frame_length = 16'($urandom_range(28, 1600));
         r.source_address = ($urandom_range(9) != 0) ? ap_pool[$urandom_range(7)]
                                                      : rand_addr();
         r.dest_address = dest_pool[$urandom_range(99)];
      end else if (pick < 760) begin
         r.func = FUNC_LOAD;
         r.ap_address = ap_pool[$urandom_range(7)];
         r.ap_chosen = ($urandom_range(9) < 8);
      end else if (pick < 770) r.func = FUNC_CLEAR;
      else if (pick < 800) r.func = 2'd3;       // unused code, must be ignored
      return r;
   endfunction

   initial begin
      logic       scan_set [8] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      logic [5:0] count_set [8] = '{6'd32, 6'd5, 6'd63, 6'd32, 6'd32, 6'd0, 6'd33, 6'd31};
      ap_pool[0] = '0;
      ap_pool[1] = BCAST_ADDR;
      for (int i = 2; i < 8; i++) ap_pool[i] = rand_addr();
      dest_pool[0] = '0;
      for (int i = 1; i < 100; i++) dest_pool[i] = rand_addr();
      dest_pool[99] = BCAST_ADDR;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: duplicate matches, unmarked entry, length edge, broadcast
      csr_write(CSR_SCAN_ENABLE, 32'd1);
      csr_write(CSR_AP_COUNT, 32'd32);
      send(load_item(0, ap_pool[2], 1));
      send(load_item(1, ap_pool[2], 1));
      send(load_item(31, BCAST_ADDR, 1));
      send(load_item(2, ap_pool[3], 0));
      send(load_item(3, '0, 1));
      send(frame_item(28, ap_pool[2], dest_pool[1]));
      send(frame_item(28, ap_pool[2], dest_pool[1]));
      send(frame_item(27, ap_pool[2], dest_pool[2]));
      send(frame_item(0, ap_pool[2], dest_pool[2]));
      send(frame_item(16'hFFFF, BCAST_ADDR, '0));
      send(frame_item(100, ap_pool[2], BCAST_ADDR));
      send(frame_item(100, ap_pool[3], dest_pool[3]));
      send(frame_item(100, '0, dest_pool[4]));
      send(make_item(2'd3, 100, ap_pool[2], dest_pool[5]));
      send(make_item(FUNC_CLEAR, 100, ap_pool[2], dest_pool[5]));
      send(frame_item(100, ap_pool[2], dest_pool[6]));
      send(load_item(1, ap_pool[2], 0));
      send(frame_item(100, ap_pool[2], dest_pool[6]));

      // fill the client table past its end
      send(make_item(FUNC_CLEAR, 0, '0, '0));
      for (int i = 0; i < 70; i++) send(frame_item(64, ap_pool[2], rand_addr()));
      drain();

      for (int p = 0; p < 8; p++) begin
         csr_write(CSR_SCAN_ENABLE, 32'(scan_set[p]));
         csr_write(CSR_AP_COUNT, 32'(count_set[p]));
         idle_mode = p % 4;
         for (int n = 0; n < 215; n++) begin
            if (p == 4 && n == 20) hold_kick <= ~hold_kick;
            if (p == 1 && n == 100) drain();
            send(random_item());
         end
         drain();
      end

      $display("%0d items sent; %0d frames matched, %0d clients learned, %0d dropped full",
               items_sent, matched_total, new_total, full_total);
      $display("register settings covered scan off/on and ap_count 0, 5, 31..33, 63");
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
